// ----- rtl/core/bps_pkg.sv -----
// ----------------------------------------------------------------------------
// bps_pkg
// Shared types and constants for the bilinear pixel scaler: register
// indexes, port widths and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package bps_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 23;
    localparam int COORD_W     = 10;
    localparam int PIXEL_W     = 32;
    localparam int SIZE_REG_W  = 8;
    localparam int STEP_W      = 23;

    localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_WIDTH    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_HEIGHT   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_HORIZONTAL_STEP = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_VERTICAL_STEP   = 2'd3;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_COMPUTE = 1'b1;

    // Neighbor select: bit 0 picks the right column, bit 1 the lower row.
    typedef struct packed {
        logic       capture;
        logic       load_we;
        logic       mul_en;
        logic       loc_en;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       acc_clr;
        logic       acc_en;
        logic       out_load;
    } bps_cmd_t;

    typedef struct packed {
        logic load_ok;
    } bps_status_t;

endpackage

// ----- rtl/core/bps_ctrl.sv -----
// ----------------------------------------------------------------------------
// bps_ctrl
// Sequencer for the scaler: takes loads without leaving idle, walks a compute
// transaction through multiply, locate, four frame store reads and the
// final round, and owns the output valid flag.
// ----------------------------------------------------------------------------
module bps_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  opcode,
    output logic                  out_valid,
    input  logic                  out_stall,
    input  bps_pkg::bps_status_t  status,
    output bps_pkg::bps_cmd_t     cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_LOC  = 3'd2;
    localparam logic [2:0] S_READ = 3'd3;
    localparam logic [2:0] S_LAST = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (opcode == bps_pkg::OP_LOAD)
                    begin
                        cmd.load_we = status.load_ok;
                    end
                    else
                    begin
                        cmd.capture = 1'b1;
                        state_next  = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = S_LOC;
            end
            S_LOC:
            begin
                cmd.loc_en  = 1'b1;
                cmd.acc_clr = 1'b1;
                cnt_next    = 2'd0;
                state_next  = S_READ;
            end
            S_READ:
            begin
                // Read neighbor cnt while summing the one fetched last cycle.
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = cnt_reg;
                cmd.acc_en = (cnt_reg != 2'd0);
                cnt_next   = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                cmd.acc_en = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // Hold until the output register is free.
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- rtl/core/bps_datapath.sv -----
// ----------------------------------------------------------------------------
// bps_datapath
// Configuration registers, frame store, coordinate mapping, weight
// generation and the four-channel blend accumulators.
// ----------------------------------------------------------------------------
module bps_datapath #(
    parameter int MAX_WIDTH     = 128,
    parameter int MAX_HEIGHT    = 128,
    parameter int FRACTION_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [bps_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [bps_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic [bps_pkg::COORD_W-1:0]         column,
    input  logic [bps_pkg::COORD_W-1:0]         row,
    input  logic [bps_pkg::PIXEL_W-1:0]         pixel_in,
    input  bps_pkg::bps_cmd_t                   cmd,
    output bps_pkg::bps_status_t                status,
    output logic [bps_pkg::PIXEL_W-1:0]         pixel_out
);

    localparam int FB    = FRACTION_BITS;
    localparam int PW    = bps_pkg::COORD_W + bps_pkg::STEP_W;
    localparam int IPW   = PW - FB;
    localparam int FW    = FB + 1;
    localparam int WW    = 2 * FB + 1;
    localparam int ACW   = 2 * FB + 10;
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int WSW   = $clog2(MAX_WIDTH + 1);
    localparam int HSW   = $clog2(MAX_HEIGHT + 1);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [FW-1:0]  ONE  = FW'(1) << FB;
    localparam logic [ACW-1:0] HALF = ACW'(1) << (2 * FB - 1);

    // Configuration
    logic [bps_pkg::SIZE_REG_W-1:0] source_width_reg;
    logic [bps_pkg::SIZE_REG_W-1:0] source_height_reg;
    logic [bps_pkg::STEP_W-1:0]     horizontal_step_reg;
    logic [bps_pkg::STEP_W-1:0]     vertical_step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_width_reg    <= 8'd128;
            source_height_reg   <= 8'd128;
            horizontal_step_reg <= 23'd65536;
            vertical_step_reg   <= 23'd65536;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bps_pkg::CFG_SOURCE_WIDTH:    source_width_reg    <= cfg_data[7:0];
                bps_pkg::CFG_SOURCE_HEIGHT:   source_height_reg   <= cfg_data[7:0];
                bps_pkg::CFG_HORIZONTAL_STEP: horizontal_step_reg <= cfg_data;
                bps_pkg::CFG_VERTICAL_STEP:   vertical_step_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Effective frame size: zero acts as one, saturate at the store size
    logic [WSW-1:0] w_size;
    logic [HSW-1:0] h_size;

    always_comb
    begin
        if (source_width_reg == '0)
            w_size = WSW'(1);
        else if (32'(source_width_reg) > MAX_WIDTH)
            w_size = WSW'(MAX_WIDTH);
        else
            w_size = WSW'(source_width_reg);

        if (source_height_reg == '0)
            h_size = HSW'(1);
        else if (32'(source_height_reg) > MAX_HEIGHT)
            h_size = HSW'(MAX_HEIGHT);
        else
            h_size = HSW'(source_height_reg);
    end

    // Coordinate capture and position multiply
    logic [bps_pkg::COORD_W-1:0] col_reg;
    logic [bps_pkg::COORD_W-1:0] row_reg;
    logic [PW-1:0]               posx_reg;
    logic [PW-1:0]               posy_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            col_reg <= column;
            row_reg <= row;
        end
        if (cmd.mul_en)
        begin
            posx_reg <= PW'(col_reg) * PW'(horizontal_step_reg);
            posy_reg <= PW'(row_reg) * PW'(vertical_step_reg);
        end
    end

    // Locate base index and fraction, clamping past the last pair
    logic [IPW-1:0] ipx;
    logic [IPW-1:0] ipy;
    logic [XW-1:0]  xb;
    logic [XW-1:0]  xn;
    logic [YW-1:0]  yb;
    logic [YW-1:0]  yn;
    logic [FW-1:0]  xf;
    logic [FW-1:0]  yf;

    assign ipx = posx_reg[PW-1:FB];
    assign ipy = posy_reg[PW-1:FB];

    always_comb
    begin
        if (w_size < WSW'(2))
        begin
            xb = '0;
            xf = '0;
            xn = '0;
        end
        else
        begin
            if (PW'(ipx) >= PW'(w_size) - PW'(1))
            begin
                xb = XW'(w_size - WSW'(2));
                xf = ONE;
            end
            else
            begin
                xb = XW'(ipx);
                xf = {1'b0, posx_reg[FB-1:0]};
            end
            xn = xb + XW'(1);
        end

        if (h_size < HSW'(2))
        begin
            yb = '0;
            yf = '0;
            yn = '0;
        end
        else
        begin
            if (PW'(ipy) >= PW'(h_size) - PW'(1))
            begin
                yb = YW'(h_size - HSW'(2));
                yf = ONE;
            end
            else
            begin
                yb = YW'(ipy);
                yf = {1'b0, posy_reg[FB-1:0]};
            end
            yn = yb + YW'(1);
        end
    end

    logic [XW-1:0] xb_reg;
    logic [XW-1:0] xn_reg;
    logic [YW-1:0] yb_reg;
    logic [YW-1:0] yn_reg;
    logic [FW-1:0] xf_reg;
    logic [FW-1:0] yf_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.loc_en)
        begin
            xb_reg <= xb;
            xn_reg <= xn;
            yb_reg <= yb;
            yn_reg <= yn;
            xf_reg <= xf;
            yf_reg <= yf;
        end
    end

    // Neighbor address and weight
    logic [XW-1:0] xsel;
    logic [YW-1:0] ysel;
    logic [FW-1:0] wx;
    logic [FW-1:0] wy;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [WW-1:0] weight_reg;

    always_comb
    begin
        xsel    = cmd.rd_sel[0] ? xn_reg : xb_reg;
        ysel    = cmd.rd_sel[1] ? yn_reg : yb_reg;
        wx      = cmd.rd_sel[0] ? xf_reg : ONE - xf_reg;
        wy      = cmd.rd_sel[1] ? yf_reg : ONE - yf_reg;
        rd_addr = AW'(32'(ysel) * MAX_WIDTH + 32'(xsel));
        wr_addr = AW'(32'(row) * MAX_WIDTH + 32'(column));
    end

    assign status.load_ok = (32'(column) < MAX_WIDTH) && (32'(row) < MAX_HEIGHT);

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            weight_reg <= WW'((2 * FW)'(wx) * (2 * FW)'(wy));
        end
    end

    // Frame store, single port
    logic [bps_pkg::PIXEL_W-1:0] frame_mem [DEPTH];
    logic [bps_pkg::PIXEL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_we)
        begin
            frame_mem[wr_addr] <= pixel_in;
        end
        else if (cmd.rd_en)
        begin
            rdata_reg <= frame_mem[rd_addr];
        end
    end

    // Per-channel blend lanes
    logic [ACW-1:0] acc_reg [4];
    logic [ACW-1:0] rnd     [4];
    logic [9:0]     chan    [4];
    logic [bps_pkg::PIXEL_W-1:0] result;

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 4; c++)
        begin
            if (cmd.acc_clr)
                acc_reg[c] <= '0;
            else if (cmd.acc_en)
                acc_reg[c] <= acc_reg[c] + ACW'(ACW'(rdata_reg[8*c +: 8]) * ACW'(weight_reg));
        end
    end

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            rnd[c]  = acc_reg[c] + HALF;
            chan[c] = rnd[c][ACW-1:2*FB];
            result[8*c +: 8] = (chan[c] > 10'd255) ? 8'hFF : chan[c][7:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            pixel_out <= result;
        end
    end

endmodule

// ----- rtl/core/bilinear_pixel_scaler.sv -----
// ----------------------------------------------------------------------------
// bilinear_pixel_scaler
// Corner-aligned bilinear scaler over an on-chip BGRA frame store. A load
// transaction (opcode 0) writes one source pixel at row * MAX_WIDTH + column,
// and the next transaction is taken in the following cycle; loads outside
// the store are dropped. A compute transaction (opcode 1) maps the
// destination column and row through the configured unsigned step
// registers, reads the four neighbors from the single-port frame store one
// per cycle, blends each channel and rounds half up. A compute holds the
// input from acceptance until its result enters the output register
// (capture, position multiply, locate, four store reads, last accumulate,
// round); the single store port makes the four reads sequential. The input
// is taken again while the previous result still waits in the output
// register. The store has no reset: reading a pixel that was never loaded
// returns undefined data. The user must write configuration through the cfg
// port only while idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module bilinear_pixel_scaler #(
    parameter int MAX_WIDTH     = 128,
    parameter int MAX_HEIGHT    = 128,
    parameter int FRACTION_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bps_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [bps_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             opcode,
    input  logic [bps_pkg::COORD_W-1:0]      column,
    input  logic [bps_pkg::COORD_W-1:0]      row,
    input  logic [bps_pkg::PIXEL_W-1:0]      pixel_in,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [bps_pkg::PIXEL_W-1:0]      pixel_out
);

    bps_pkg::bps_cmd_t    cmd;
    bps_pkg::bps_status_t status;

    assign cfg_ready = 1'b1;

    bps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    bps_datapath #(
        .MAX_WIDTH     (MAX_WIDTH),
        .MAX_HEIGHT    (MAX_HEIGHT),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .column    (column),
        .row       (row),
        .pixel_in  (pixel_in),
        .cmd       (cmd),
        .status    (status),
        .pixel_out (pixel_out)
    );

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bilinear pixel scaler. Source pixels are loaded
// into the frame store and destination pixels are queried under a series of
// size and step settings. A local blend predictor tracks the store contents
// and the register values and checks every returned pixel in order. The
// sender runs in random bursts, the receiver stalls in changing patterns.
// ----------------------------------------------------------------------------
module testbench;

    localparam int MAX_WIDTH     = 128;
    localparam int MAX_HEIGHT    = 128;
    localparam int FRACTION_BITS = 16;
    localparam int STORE_DEPTH   = MAX_WIDTH * MAX_HEIGHT;
    localparam int ITEM_TARGET   = 1350;
    localparam int DRAIN_CYCLES  = 16;
    localparam int IDLE_LIMIT    = 4000;

    localparam logic [63:0]                UNIT     = 64'd1 << FRACTION_BITS;
    localparam logic [63:0]                HALF_LSB = 64'd1 << (2 * FRACTION_BITS - 1);
    localparam logic [bps_pkg::STEP_W-1:0] STEP_MAX = 23'd8323072;
    localparam logic [bps_pkg::STEP_W-1:0] STEP_ONE = 23'd65536;

    typedef struct {
        logic                        op;
        logic [bps_pkg::COORD_W-1:0] column;
        logic [bps_pkg::COORD_W-1:0] row;
        logic [bps_pkg::PIXEL_W-1:0] pixel;
    } scaler_item_t;

    typedef struct {
        logic [bps_pkg::SIZE_REG_W-1:0] width;
        logic [bps_pkg::SIZE_REG_W-1:0] height;
        logic [bps_pkg::STEP_W-1:0]     hstep;
        logic [bps_pkg::STEP_W-1:0]     vstep;
    } scale_cfg_t;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [bps_pkg::CFG_INDEX_W-1:0] cfg_index = bps_pkg::CFG_SOURCE_WIDTH;
    logic [bps_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                            in_valid  = 1'b0;
    logic                            in_stall;
    logic                            opcode    = bps_pkg::OP_LOAD;
    logic [bps_pkg::COORD_W-1:0]     column    = '0;
    logic [bps_pkg::COORD_W-1:0]     row       = '0;
    logic [bps_pkg::PIXEL_W-1:0]     pixel_in  = '0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    logic [bps_pkg::PIXEL_W-1:0]     pixel_out;

    scaler_item_t                pending_items[$];
    logic [bps_pkg::PIXEL_W-1:0] pixel_expect[$];
    logic [bps_pkg::PIXEL_W-1:0] frame_model [0:STORE_DEPTH-1];
    bit                          store_planned [0:STORE_DEPTH-1];
    scale_cfg_t                  live_cfg;
    scale_cfg_t                  plan_cfg;

    int queued_total    = 0;
    int accepted_total  = 0;
    int counted_items   = 0;
    int pixels_compared = 0;
    int mismatches      = 0;
    int phases_run      = 0;
    int idle_cycles     = 0;
    int burst_left      = 0;
    int gap_left        = 0;
    int stall_mode      = 0;
    int stall_left      = 0;
    int stall_tick      = 0;
    scaler_item_t next_item;

    bilinear_pixel_scaler #(
        .MAX_WIDTH     (MAX_WIDTH),
        .MAX_HEIGHT    (MAX_HEIGHT),
        .FRACTION_BITS (FRACTION_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .column    (column),
        .row       (row),
        .pixel_in  (pixel_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .pixel_out (pixel_out)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Blend predictor
    // ------------------------------------------------------------------------
    function automatic int eff_size(input logic [bps_pkg::SIZE_REG_W-1:0] v, input int limit);
        if (v == 0)
            return 1;
        if (v > limit)
            return limit;
        return v;
    endfunction

    function automatic void locate_axis(input logic [bps_pkg::COORD_W-1:0] coord,
                                        input logic [bps_pkg::STEP_W-1:0] step,
                                        input int size,
                                        output int base, output logic [16:0] frac);
        logic [33:0] pos;
        pos = 34'(coord) * 34'(step);
        if (size < 2)
        begin
            base = 0;
            frac = '0;
        end
        else if (pos[33:FRACTION_BITS] >= size - 1)
        begin
            // Past the last pair: pin to the last pair at full weight
            base = size - 2;
            frac = 17'h10000;
        end
        else
        begin
            base = int'(pos[33:FRACTION_BITS]);
            frac = {1'b0, pos[FRACTION_BITS-1:0]};
        end
    endfunction

    function automatic void find_neighbors(input scale_cfg_t c,
                                           input logic [bps_pkg::COORD_W-1:0] col,
                                           input logic [bps_pkg::COORD_W-1:0] rw,
                                           output int x0, output int x1,
                                           output int y0, output int y1,
                                           output logic [16:0] fx, output logic [16:0] fy);
        int w;
        int h;
        w = eff_size(c.width, MAX_WIDTH);
        h = eff_size(c.height, MAX_HEIGHT);
        locate_axis(col, c.hstep, w, x0, fx);
        locate_axis(rw, c.vstep, h, y0, fy);
        x1 = (w >= 2) ? x0 + 1 : x0;
        y1 = (h >= 2) ? y0 + 1 : y0;
    endfunction

    function automatic logic [bps_pkg::PIXEL_W-1:0] predict_pixel(
        input logic [bps_pkg::COORD_W-1:0] col,
        input logic [bps_pkg::COORD_W-1:0] rw);
        int x0, x1, y0, y1;
        logic [16:0] fx, fy;
        logic [63:0] wa, wb, wc, wd, acc;
        logic [bps_pkg::PIXEL_W-1:0] q00, q10, q01, q11, result;
        find_neighbors(live_cfg, col, rw, x0, x1, y0, y1, fx, fy);
        q00 = frame_model[y0 * MAX_WIDTH + x0];
        q10 = frame_model[y0 * MAX_WIDTH + x1];
        q01 = frame_model[y1 * MAX_WIDTH + x0];
        q11 = frame_model[y1 * MAX_WIDTH + x1];
        wa = (UNIT - 64'(fx)) * (UNIT - 64'(fy));
        wb = 64'(fx) * (UNIT - 64'(fy));
        wc = (UNIT - 64'(fx)) * 64'(fy);
        wd = 64'(fx) * 64'(fy);
        result = '0;
        for (int ch = 0; ch < 4; ch++)
        begin
            acc = 64'(q00[8*ch +: 8]) * wa + 64'(q10[8*ch +: 8]) * wb
                + 64'(q01[8*ch +: 8]) * wc + 64'(q11[8*ch +: 8]) * wd;
            acc = (acc + HALF_LSB) >> (2 * FRACTION_BITS);
            if (acc > 255)
                acc = 255;
            result[8*ch +: 8] = acc[7:0];
        end
        return result;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [bps_pkg::PIXEL_W-1:0] random_pixel();
        logic [bps_pkg::PIXEL_W-1:0] p;
        case ($urandom_range(0, 7))
            0: p = '0;
            1: p = '1;
            2:
            begin
                for (int b = 0; b < 4; b++)
                    p[8*b +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
            default: p = $urandom;
        endcase
        return p;
    endfunction

    function automatic logic [bps_pkg::COORD_W-1:0] pick_coord(input int extent);
        if ($urandom_range(0, 6) != 0)
            return bps_pkg::COORD_W'($urandom_range(0, extent));
        return bps_pkg::COORD_W'($urandom_range(0, 1023));
    endfunction

    function automatic logic [bps_pkg::SIZE_REG_W-1:0] choose_size();
        case ($urandom_range(0, 19))
            0: return '0;
            1: return bps_pkg::SIZE_REG_W'(1);
            2: return bps_pkg::SIZE_REG_W'(MAX_WIDTH);
            3: return bps_pkg::SIZE_REG_W'($urandom_range(MAX_WIDTH + 1, 255));
            4, 5, 6: return bps_pkg::SIZE_REG_W'($urandom_range(17, MAX_WIDTH));
            default: return bps_pkg::SIZE_REG_W'($urandom_range(2, 16));
        endcase
    endfunction

    // Corner-aligned step for a destination of extent+1 pixels, or an odd value
    function automatic logic [bps_pkg::STEP_W-1:0] choose_step(input int eff,
                                                               output int extent);
        extent = $urandom_range(1, 64);
        case ($urandom_range(0, 9))
            0: return '0;
            1: return STEP_MAX;
            2: return bps_pkg::STEP_W'($urandom_range(0, 23'h7FFFFF));
            default: return bps_pkg::STEP_W'(((eff - 1) << FRACTION_BITS) / extent);
        endcase
    endfunction

    task automatic queue_load(input int col, input int rw,
                              input logic [bps_pkg::PIXEL_W-1:0] pix);
        scaler_item_t it;
        it.op     = bps_pkg::OP_LOAD;
        it.column = bps_pkg::COORD_W'(col);
        it.row    = bps_pkg::COORD_W'(rw);
        it.pixel  = pix;
        pending_items.push_back(it);
        queued_total++;
        if (col < MAX_WIDTH && rw < MAX_HEIGHT)
        begin
            store_planned[rw * MAX_WIDTH + col] = 1'b1;
            counted_items++;
        end
    endtask

    task automatic queue_missing(input int col, input int rw);
        if (!store_planned[rw * MAX_WIDTH + col])
            queue_load(col, rw, random_pixel());
    endtask

    // Fill any neighbor not yet loaded, then issue the query
    task automatic queue_compute(input logic [bps_pkg::COORD_W-1:0] col,
                                 input logic [bps_pkg::COORD_W-1:0] rw);
        scaler_item_t it;
        int x0, x1, y0, y1;
        logic [16:0] fx, fy;
        find_neighbors(plan_cfg, col, rw, x0, x1, y0, y1, fx, fy);
        queue_missing(x0, y0);
        queue_missing(x1, y0);
        queue_missing(x0, y1);
        queue_missing(x1, y1);
        it.op     = bps_pkg::OP_COMPUTE;
        it.column = col;
        it.row    = rw;
        it.pixel  = $urandom;
        pending_items.push_back(it);
        queued_total++;
        counted_items++;
    endtask

    task automatic queue_outside_load();
        if ($urandom_range(0, 1))
            queue_load($urandom_range(MAX_WIDTH, 1023), $urandom_range(0, 1023),
                       random_pixel());
        else
            queue_load($urandom_range(0, 1023), $urandom_range(MAX_HEIGHT, 1023),
                       random_pixel());
    endtask

    task automatic write_register(input logic [bps_pkg::CFG_INDEX_W-1:0] idx,
                                  input logic [bps_pkg::CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic program_scaler(input scale_cfg_t c, input logic [14:0] size_upper);
        plan_cfg = c;
        write_register(bps_pkg::CFG_SOURCE_WIDTH, {size_upper, c.width});
        write_register(bps_pkg::CFG_SOURCE_HEIGHT, {size_upper, c.height});
        write_register(bps_pkg::CFG_HORIZONTAL_STEP, c.hstep);
        write_register(bps_pkg::CFG_VERTICAL_STEP, c.vstep);
        cfg_valid <= 1'b0;
        phases_run++;
    endtask

    // Hold until every transaction is in and every pixel is out, then let
    // trailing loads settle
    task automatic wait_drained();
        while (accepted_total != queued_total || pixel_expect.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Driver: bursts of transactions with random gaps
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && (!in_valid || !in_stall))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                next_item = pending_items.pop_front();
                in_valid <= 1'b1;
                opcode   <= next_item.op;
                column   <= next_item.column;
                row      <= next_item.row;
                pixel_in <= next_item.pixel;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(0, 15);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver stall: switch between free-running, random, periodic and long runs
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(40, 250);
        end
        else
            stall_left--;
        stall_tick++;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 2) == 0);
            2: out_stall <= (stall_tick % 7) < 3;
            default: out_stall <= ($urandom_range(0, 7) == 0) ? !out_stall : out_stall;
        endcase
    end

    // ------------------------------------------------------------------------
    // Monitor: register updates, store updates, result checks
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pixel_expect.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: pixel %08h returned with no query pending",
                                 $realtime, pixel_out);
                    mismatches++;
                end
                else
                begin
                    if (pixel_out !== pixel_expect[0])
                    begin
                        if (mismatches < 10)
                            $display("%0t: pixel_out mismatch, expected %08h, got %08h",
                                     $realtime, pixel_expect[0], pixel_out);
                        mismatches++;
                    end
                    void'(pixel_expect.pop_front());
                    pixels_compared++;
                end
            end
            if (in_valid && !in_stall)
            begin
                accepted_total++;
                if (opcode == bps_pkg::OP_COMPUTE)
                    pixel_expect.push_back(predict_pixel(column, row));
                else if (column < MAX_WIDTH && row < MAX_HEIGHT)
                    frame_model[row * MAX_WIDTH + column] = pixel_in;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    bps_pkg::CFG_SOURCE_WIDTH:
                        live_cfg.width  = cfg_data[bps_pkg::SIZE_REG_W-1:0];
                    bps_pkg::CFG_SOURCE_HEIGHT:
                        live_cfg.height = cfg_data[bps_pkg::SIZE_REG_W-1:0];
                    bps_pkg::CFG_HORIZONTAL_STEP:
                        live_cfg.hstep  = cfg_data[bps_pkg::STEP_W-1:0];
                    bps_pkg::CFG_VERTICAL_STEP:
                        live_cfg.vstep  = cfg_data[bps_pkg::STEP_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("no transaction for %0d cycles, %0d pixels outstanding",
                     IDLE_LIMIT, pixel_expect.size());
            $display("testbench failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        scale_cfg_t c;
        int dst_cols, dst_rows, ops, r, eff_w, eff_h;
        logic [14:0] upper;

        live_cfg = '{bps_pkg::SIZE_REG_W'(MAX_WIDTH), bps_pkg::SIZE_REG_W'(MAX_HEIGHT),
                     STEP_ONE, STEP_ONE};
        plan_cfg = live_cfg;
        for (int i = 0; i < STORE_DEPTH; i++)
            frame_model[i] = '0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: unit step over the full frame
        queue_load(0, 0, 32'hFFFF_FFFF);
        queue_load(1, 0, 32'h0000_0000);
        queue_load(0, 1, 32'h00FF_00FF);
        queue_load(1, 1, 32'hFF00_FF00);
        queue_compute(10'd0, 10'd0);
        queue_compute(10'd1, 10'd0);
        queue_compute(10'd127, 10'd0);
        queue_compute(10'd1023, 10'd1023);
        queue_load(MAX_WIDTH, 0, 32'hFFFF_FFFF);
        queue_load(0, MAX_HEIGHT, 32'hFFFF_FFFF);
        queue_load(1023, 1023, 32'hFFFF_FFFF);
        queue_compute(10'd0, 10'd0);
        queue_load(127, 127, 32'h5A5A_A5A5);
        queue_compute(10'd126, 10'd127);
        wait_drained();

        // Half step on a two-pixel row: exact halves round up
        program_scaler('{8'd2, 8'd1, 23'h8000, 23'h0}, '0);
        queue_load(0, 0, 32'h0000_0000);
        queue_load(1, 0, 32'h01FF_0301);
        queue_compute(10'd1, 10'd0);
        queue_compute(10'd2, 10'd0);
        queue_compute(10'd3, 10'd5);
        wait_drained();

        while (counted_items < ITEM_TARGET)
        begin
            c.width  = choose_size();
            c.height = choose_size();
            eff_w = eff_size(c.width, MAX_WIDTH);
            eff_h = eff_size(c.height, MAX_HEIGHT);
            c.hstep = choose_step(eff_w, dst_cols);
            c.vstep = choose_step(eff_h, dst_rows);
            case (phases_run)
                2:
                begin
                    c.width  = 8'd1;
                    c.height = 8'd1;
                end
                3:
                begin
                    c.width  = 8'd0;
                    c.height = 8'd255;
                    c.hstep  = '0;
                    c.vstep  = STEP_MAX;
                end
                4:
                begin
                    c.width  = bps_pkg::SIZE_REG_W'(MAX_WIDTH);
                    c.height = bps_pkg::SIZE_REG_W'(MAX_HEIGHT);
                    c.hstep  = STEP_MAX;
                    c.vstep  = STEP_MAX;
                end
                default: ;
            endcase
            eff_w = eff_size(c.width, MAX_WIDTH);
            eff_h = eff_size(c.height, MAX_HEIGHT);
            upper = ($urandom_range(0, 9) < 3) ? 15'($urandom) : '0;
            program_scaler(c, upper);

            ops = $urandom_range(40, 120);
            repeat (ops)
            begin
                r = $urandom_range(0, 9);
                if (r < 7)
                    queue_compute(pick_coord(dst_cols), pick_coord(dst_rows));
                else if (r < 9)
                    queue_load($urandom_range(0, eff_w - 1), $urandom_range(0, eff_h - 1),
                               random_pixel());
                else
                    queue_outside_load();
            end
            wait_drained();
        end

        wait_drained();
        $display("covered %0d register settings and %0d accepted transactions",
                 phases_run, accepted_total);
        $display("compared %0d pixels, %0d mismatches", pixels_compared, mismatches);
        if (mismatches == 0 && pixel_expect.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
